FILE: hw/rtl/cir_pkg.sv
// Shared types, constants and helpers for the collision impulse pipeline.
package cir_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 32;
  localparam int NUM_LANES = 3;

  // (e + 1) in Q.17 is ra + rb + one in Q.17
  localparam logic [18:0] K_ONE = 19'h20000;
  localparam logic [31:0] J_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               dyn_a;
    logic               dyn_b;
    logic               go;
    logic        [37:0] p;
    logic        [31:0] m_alt;
  } cir_ctx_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [33:0] div_step(logic [32:0] rem, logic b, logic [32:0] den);
    logic [33:0] r2;
    logic [33:0] diff;
    r2   = {rem, b};
    diff = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      return {1'b1, diff[32:0]};
    end else begin
      return {1'b0, r2[32:0]};
    end
  endfunction

  function automatic logic [31:0] sat32(logic signed [42:0] v);
    if ((&v[42:31]) || !(|v[42:31])) begin
      return v[31:0];
    end else if (v[42]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

FILE: hw/rtl/cir_div.sv
// Pipelined restoring divider, three dividends over one shared divisor.
module cir_div import cir_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cir_ctx_t      in_ctx,
  input  logic [32:0]   den,
  input  logic [63:0]   num0,
  input  logic [63:0]   num1,
  input  logic [63:0]   num2,
  output logic          out_valid,
  output cir_ctx_t      out_ctx,
  output logic [31:0]   q0,
  output logic [31:0]   q1,
  output logic [31:0]   q2
);

  logic                 vld  [1:DIV_STEPS];
  cir_ctx_t             ctx  [1:DIV_STEPS];
  logic [32:0]          dn   [1:DIV_STEPS];
  logic [32:0]          rem  [1:DIV_STEPS][0:NUM_LANES-1];
  logic [DIV_STEPS-1:0] rest [1:DIV_STEPS][0:NUM_LANES-1];
  logic [DIV_STEPS-1:0] quo  [1:DIV_STEPS][0:NUM_LANES-1];
  logic [63:0]          num  [0:NUM_LANES-1];

  assign num[0] = num0;
  assign num[1] = num1;
  assign num[2] = num2;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    logic        v_in;
    cir_ctx_t    c_in;
    logic [32:0] d_in;

    if (s == 0) begin : g_head
      assign v_in = in_valid;
      assign c_in = in_ctx;
      assign d_in = den;
    end else begin : g_body
      assign v_in = vld[s];
      assign c_in = ctx[s];
      assign d_in = dn[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx[s+1] <= c_in;
        dn[s+1]  <= d_in;
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [32:0]          r_in;
      logic [DIV_STEPS-1:0] t_in;
      logic [DIV_STEPS-1:0] q_in;
      logic [33:0]          stp;

      if (s == 0) begin : g_head
        // The upper half of each dividend is known to be below the divisor.
        assign r_in = {1'b0, num[l][63:32]};
        assign t_in = num[l][31:0];
        assign q_in = '0;
      end else begin : g_body
        assign r_in = rem[s][l];
        assign t_in = rest[s][l];
        assign q_in = quo[s][l];
      end

      assign stp = div_step(r_in, t_in[DIV_STEPS-1], d_in);

      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1][l]  <= stp[32:0];
          rest[s+1][l] <= {t_in[DIV_STEPS-2:0], 1'b0};
          quo[s+1][l]  <= {q_in[DIV_STEPS-2:0], stp[33]};
        end
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_ctx   = ctx[DIV_STEPS];
  assign q0        = quo[DIV_STEPS][0];
  assign q1        = quo[DIV_STEPS][1];
  assign q2        = quo[DIV_STEPS][2];

endmodule

FILE: hw/rtl/collision_impulse_response_top.sv
// Contact-pair impulse resolver with restitution, fully pipelined.
//
// One contact pair is taken every cycle unless out_stall holds a result:
// four stages form the relative normal speed and (e+1)|Vn|, a 32-stage
// restoring divider produces the effective mass and both mass ratios, and
// four more stages form the impulse, the per-axis velocity changes and the
// saturated new velocities. The divider sets the latency. While a result is
// held by out_stall the whole pipeline freezes, so in_stall follows it.
module collision_impulse_response_top import cir_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] velocity_a_x,
  input  logic signed [31:0] velocity_a_y,
  input  logic        [31:0] mass_a,
  input  logic signed [31:0] velocity_b_x,
  input  logic signed [31:0] velocity_b_y,
  input  logic        [31:0] mass_b,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic        [16:0] restitution_a,
  input  logic        [16:0] restitution_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_velocity_a_x,
  output logic signed [31:0] new_velocity_a_y,
  output logic signed [31:0] new_velocity_b_x,
  output logic signed [31:0] new_velocity_b_y,
  output logic               apply_a,
  output logic               apply_b,
  output logic signed [31:0] impulse
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // ---- stage 1: input register
  logic               s1_valid;
  cir_ctx_t           s1_ctx;
  logic [31:0]        s1_ma, s1_mb;
  logic [16:0]        s1_ra, s1_rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctx.vax   <= velocity_a_x;
      s1_ctx.vay   <= velocity_a_y;
      s1_ctx.vbx   <= velocity_b_x;
      s1_ctx.vby   <= velocity_b_y;
      s1_ctx.nx    <= normal_x;
      s1_ctx.ny    <= normal_y;
      s1_ctx.dyn_a <= |mass_a;
      s1_ctx.dyn_b <= |mass_b;
      s1_ctx.go    <= 1'b0;
      s1_ctx.p     <= '0;
      s1_ctx.m_alt <= mass_a | mass_b;
      s1_ma        <= mass_a;
      s1_mb        <= mass_b;
      s1_ra        <= restitution_a;
      s1_rb        <= restitution_b;
    end
  end

  // ---- stage 2: normal projections, mass product and sum
  logic signed [32:0] dx_c, dy_c;
  logic signed [48:0] px_c, py_c;
  assign dx_c = (s1_ctx.dyn_b ? 33'(s1_ctx.vbx) : 33'sd0)
              - (s1_ctx.dyn_a ? 33'(s1_ctx.vax) : 33'sd0);
  assign dy_c = (s1_ctx.dyn_b ? 33'(s1_ctx.vby) : 33'sd0)
              - (s1_ctx.dyn_a ? 33'(s1_ctx.vay) : 33'sd0);
  assign px_c = dx_c * s1_ctx.nx;
  assign py_c = dy_c * s1_ctx.ny;

  logic               s2_valid;
  cir_ctx_t           s2_ctx;
  logic signed [48:0] s2_px, s2_py;
  logic [18:0]        s2_k;
  logic [63:0]        s2_prod;
  logic [32:0]        s2_sum;
  logic [31:0]        s2_ma, s2_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctx  <= s1_ctx;
      s2_px   <= px_c;
      s2_py   <= py_c;
      s2_k    <= 19'(s1_ra) + 19'(s1_rb) + K_ONE;
      s2_prod <= 64'(s1_ma) * 64'(s1_mb);
      s2_sum  <= 33'(s1_ma) + 33'(s1_mb);
      s2_ma   <= s1_ma;
      s2_mb   <= s1_mb;
    end
  end

  // ---- stage 3: relative normal speed and the approach test
  logic signed [49:0] vn_c;
  cir_ctx_t           s3_ctx_next;
  assign vn_c = 50'(s2_px) + 50'(s2_py);

  always_comb begin
    s3_ctx_next    = s2_ctx;
    s3_ctx_next.go = vn_c[49] && (s2_ctx.dyn_a || s2_ctx.dyn_b);
  end

  logic               s3_valid;
  cir_ctx_t           s3_ctx;
  logic signed [49:0] s3_vn;
  logic [18:0]        s3_k;
  logic [63:0]        s3_prod;
  logic [32:0]        s3_sum;
  logic [31:0]        s3_ma, s3_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctx    <= s3_ctx_next;
      s3_vn     <= vn_c;
      s3_k      <= s2_k;
      s3_prod   <= s2_prod;
      s3_sum    <= s2_sum;
      s3_ma     <= s2_ma;
      s3_mb     <= s2_mb;
    end
  end

  // ---- stage 4: P = ((|Vn| >> 14) * k) >> 17
  logic [49:0] mag_c;
  logic [54:0] pk_c;
  cir_ctx_t    s4_ctx_next;
  assign mag_c = 50'(-s3_vn);
  assign pk_c  = 55'(mag_c[49:14]) * 55'(s3_k);

  always_comb begin
    s4_ctx_next   = s3_ctx;
    s4_ctx_next.p = pk_c[54:17];
  end

  logic        s4_valid;
  cir_ctx_t    s4_ctx;
  logic [63:0] s4_prod;
  logic [32:0] s4_sum;
  logic [31:0] s4_ma, s4_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ctx   <= s4_ctx_next;
      s4_prod  <= s3_prod;
      s4_sum   <= s3_sum;
      s4_ma    <= s3_ma;
      s4_mb    <= s3_mb;
    end
  end

  // ---- divider: meff = ma*mb/sum, mb<<16/sum, ma<<16/sum
  logic        dv_valid;
  cir_ctx_t    dv_ctx;
  logic [31:0] dv_q0, dv_q1, dv_q2;

  cir_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .in_ctx    (s4_ctx),
    .den       (s4_sum),
    .num0      (s4_prod),
    .num1      ({16'h0, s4_mb, 16'h0}),
    .num2      ({16'h0, s4_ma, 16'h0}),
    .out_valid (dv_valid),
    .out_ctx   (dv_ctx),
    .q0        (dv_q0),
    .q1        (dv_q1),
    .q2        (dv_q2)
  );

  // ---- stage 5: impulse partial products and ratio products
  logic        both_c;
  logic [31:0] meff_c;
  assign both_c = dv_ctx.dyn_a && dv_ctx.dyn_b;
  assign meff_c = both_c ? dv_q0 : dv_ctx.m_alt;

  logic        s5_valid;
  cir_ctx_t    s5_ctx;
  logic [63:0] s5_j_lo;
  logic [37:0] s5_j_hi;
  logic [54:0] s5_da_full, s5_db_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ctx     <= dv_ctx;
      s5_j_lo    <= 64'(dv_ctx.p[31:0]) * 64'(meff_c);
      s5_j_hi    <= 38'(dv_ctx.p[37:32]) * 38'(meff_c);
      s5_da_full <= 55'(dv_ctx.p) * 55'(dv_q1[16:0]);
      s5_db_full <= 55'(dv_ctx.p) * 55'(dv_q2[16:0]);
    end
  end

  // ---- stage 6: impulse with saturation, change magnitudes
  logic [70:0] jfull_c;
  logic [54:0] js_c;
  logic        s5_both;
  assign jfull_c = 71'(s5_j_lo) + 71'({s5_j_hi, 32'h0});
  assign js_c    = jfull_c[70:FRAC_BITS];
  assign s5_both = s5_ctx.dyn_a && s5_ctx.dyn_b;

  logic        s6_valid;
  cir_ctx_t    s6_ctx;
  logic [31:0] s6_j;
  logic [38:0] s6_da, s6_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ctx <= s5_ctx;
      if (!s5_ctx.go) begin
        s6_j <= '0;
      end else if (js_c > 55'(J_MAX)) begin
        s6_j <= J_MAX;
      end else begin
        s6_j <= js_c[31:0];
      end
      s6_da <= s5_both ? s5_da_full[54:16] : {1'b0, s5_ctx.p};
      s6_db <= s5_both ? s5_db_full[54:16] : {1'b0, s5_ctx.p};
    end
  end

  // ---- stage 7: per-axis change magnitudes, D * |n| >> 14
  logic [15:0] anx_c, any_c;
  logic [54:0] tax_c, tay_c, tbx_c, tby_c;
  assign anx_c = s6_ctx.nx[15] ? 16'(-s6_ctx.nx) : 16'(s6_ctx.nx);
  assign any_c = s6_ctx.ny[15] ? 16'(-s6_ctx.ny) : 16'(s6_ctx.ny);
  assign tax_c = 55'(s6_da) * 55'(anx_c);
  assign tay_c = 55'(s6_da) * 55'(any_c);
  assign tbx_c = 55'(s6_db) * 55'(anx_c);
  assign tby_c = 55'(s6_db) * 55'(any_c);

  logic        s7_valid;
  cir_ctx_t    s7_ctx;
  logic [31:0] s7_j;
  logic [40:0] s7_tax, s7_tay, s7_tbx, s7_tby;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_ctx <= s6_ctx;
      s7_j   <= s6_j;
      s7_tax <= tax_c[54:14];
      s7_tay <= tay_c[54:14];
      s7_tbx <= tbx_c[54:14];
      s7_tby <= tby_c[54:14];
    end
  end

  // ---- stage 8: apply the changes, output register
  logic signed [42:0] tax_s, tay_s, tbx_s, tby_s;
  logic signed [42:0] nax_c, nay_c, nbx_c, nby_c;
  assign tax_s = s7_ctx.nx[15] ? -$signed({2'b0, s7_tax}) : $signed({2'b0, s7_tax});
  assign tay_s = s7_ctx.ny[15] ? -$signed({2'b0, s7_tay}) : $signed({2'b0, s7_tay});
  assign tbx_s = s7_ctx.nx[15] ? -$signed({2'b0, s7_tbx}) : $signed({2'b0, s7_tbx});
  assign tby_s = s7_ctx.ny[15] ? -$signed({2'b0, s7_tby}) : $signed({2'b0, s7_tby});
  assign nax_c = 43'(s7_ctx.vax) - tax_s;
  assign nay_c = 43'(s7_ctx.vay) - tay_s;
  assign nbx_c = 43'(s7_ctx.vbx) + tbx_s;
  assign nby_c = 43'(s7_ctx.vby) + tby_s;

  logic app_a_c, app_b_c;
  assign app_a_c = s7_ctx.go && s7_ctx.dyn_a;
  assign app_b_c = s7_ctx.go && s7_ctx.dyn_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_velocity_a_x <= app_a_c ? sat32(nax_c) : s7_ctx.vax;
      new_velocity_a_y <= app_a_c ? sat32(nay_c) : s7_ctx.vay;
      new_velocity_b_x <= app_b_c ? sat32(nbx_c) : s7_ctx.vbx;
      new_velocity_b_y <= app_b_c ? sat32(nby_c) : s7_ctx.vby;
      apply_a          <= app_a_c;
      apply_b          <= app_b_c;
      impulse          <= s7_j;
    end
  end

endmodule

FILE: hw/rtl/cir_chk.sv
// Port-level checks for the collision impulse pipeline, bound to the top level.
module cir_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               apply_a,
  input logic               apply_b,
  input logic signed [31:0] impulse,
  input logic signed [31:0] new_velocity_a_x
);

  // a held result keeps its impulse and new_velocity_a_x
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(impulse) && $stable(new_velocity_a_x))
    else $error("held result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output held");

  a_impulse_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !impulse[31])
    else $error("negative impulse");

  a_impulse_apply: assert property (@(posedge clk) disable iff (rst)
    out_valid && (impulse != 0) |-> apply_a || apply_b)
    else $error("impulse without applied body");

endmodule

bind collision_impulse_response_top cir_chk u_cir_chk (.*);

FILE: sim/collision_impulse_response_top_tb.sv
// Self-checking testbench for the collision impulse resolver pipeline.
module collision_impulse_response_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cir_pkg::*;

  localparam int LATENCY     = 40;
  localparam int WATCH_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic        [31:0] ma;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic        [31:0] mb;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic        [16:0] ra;
    logic        [16:0] rb;
  } contact_t;

  typedef struct packed {
    logic signed [31:0] nvax;
    logic signed [31:0] nvay;
    logic signed [31:0] nvbx;
    logic signed [31:0] nvby;
    logic               app_a;
    logic               app_b;
    logic signed [31:0] imp;
  } response_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  contact_t  cur;
  logic signed [31:0] new_velocity_a_x, new_velocity_a_y;
  logic signed [31:0] new_velocity_b_x, new_velocity_b_y;
  logic apply_a, apply_b;
  logic signed [31:0] impulse;

  contact_t  pending_contacts[$];
  response_t expected_responses[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_gap = 0, recv_gap = 0;
  int  hold_left = 0;
  bit  random_gaps = 1;
  bit  in_accepted = 0;

  collision_impulse_response_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .velocity_a_x(cur.vax), .velocity_a_y(cur.vay), .mass_a(cur.ma),
    .velocity_b_x(cur.vbx), .velocity_b_y(cur.vby), .mass_b(cur.mb),
    .normal_x(cur.nx), .normal_y(cur.ny),
    .restitution_a(cur.ra), .restitution_b(cur.rb),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_velocity_a_x(new_velocity_a_x), .new_velocity_a_y(new_velocity_a_y),
    .new_velocity_b_x(new_velocity_b_x), .new_velocity_b_y(new_velocity_b_y),
    .apply_a(apply_a), .apply_b(apply_b), .impulse(impulse)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // d * n / 2^14, truncated toward zero
  function automatic longint along_normal(logic [63:0] d, longint n);
    logic [63:0] mag;
    longint r;
    mag = (n < 0) ? -n : n;
    r = longint'((d * mag) >> 14);
    return (n < 0) ? -r : r;
  endfunction

  function automatic response_t resolve_contact(contact_t c);
    response_t r;
    logic dyn_a, dyn_b;
    longint ua_x, ua_y, ub_x, ub_y, vn;
    logic [63:0] m, k, p, meff, da, db, sum, j;
    dyn_a = c.ma != 0;
    dyn_b = c.mb != 0;
    ua_x = dyn_a ? longint'(c.vax) : 0;
    ua_y = dyn_a ? longint'(c.vay) : 0;
    ub_x = dyn_b ? longint'(c.vbx) : 0;
    ub_y = dyn_b ? longint'(c.vby) : 0;
    vn = (ub_x - ua_x) * longint'(c.nx) + (ub_y - ua_y) * longint'(c.ny);
    r.nvax = c.vax; r.nvay = c.vay; r.nvbx = c.vbx; r.nvby = c.vby;
    r.app_a = 1'b0; r.app_b = 1'b0; r.imp = '0;
    if (vn < 0 && (dyn_a || dyn_b)) begin
      m = (64'd0 - 64'(vn)) >> 14;
      k = 64'(c.ra) + 64'(c.rb) + 64'd131072;
      p = (m * k) >> 17;
      if (dyn_a && dyn_b) begin
        sum = 64'(c.ma) + 64'(c.mb);
        meff = (64'(c.ma) * 64'(c.mb)) / sum;
        da = (p * ((64'(c.mb) << 16) / sum)) >> 16;
        db = (p * ((64'(c.ma) << 16) / sum)) >> 16;
      end else begin
        meff = dyn_a ? 64'(c.ma) : 64'(c.mb);
        da = p;
        db = p;
      end
      if (p != 0 && meff > 64'hFFFF_FFFF_FFFF_FFFF / p) j = 64'h7FFF_FFFF;
      else begin
        j = (p * meff) >> FRAC_BITS;
        if (j > 64'h7FFF_FFFF) j = 64'h7FFF_FFFF;
      end
      r.imp = j[31:0];
      if (dyn_a) begin
        r.nvax = clamp32(longint'(c.vax) - along_normal(da, c.nx));
        r.nvay = clamp32(longint'(c.vay) - along_normal(da, c.ny));
        r.app_a = 1'b1;
      end
      if (dyn_b) begin
        r.nvbx = clamp32(longint'(c.vbx) + along_normal(db, c.nx));
        r.nvby = clamp32(longint'(c.vby) + along_normal(db, c.ny));
        r.app_b = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // sender: payload held until the rising edge takes it
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cur <= '0;
    end else if (!in_valid || in_accepted) begin
      if (in_valid) send_gap = random_gaps ? $urandom_range(0, 14) : 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_contacts.size() > 0) begin
        cur <= pending_contacts.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && random_gaps) recv_gap = $urandom_range(0, 14);
    end
  end

  always @(posedge clk) begin
    in_accepted = in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) expected_responses.push_back(resolve_contact(cur));
      if (out_valid && !out_stall) begin
        response_t w;
        if (expected_responses.size() == 0) begin
          report_mismatch("result with nothing expected", 0, 0);
        end else begin
          w = expected_responses.pop_front();
          if (new_velocity_a_x !== w.nvax)
            report_mismatch("new_velocity_a_x", new_velocity_a_x, w.nvax);
          if (new_velocity_a_y !== w.nvay)
            report_mismatch("new_velocity_a_y", new_velocity_a_y, w.nvay);
          if (new_velocity_b_x !== w.nvbx)
            report_mismatch("new_velocity_b_x", new_velocity_b_x, w.nvbx);
          if (new_velocity_b_y !== w.nvby)
            report_mismatch("new_velocity_b_y", new_velocity_b_y, w.nvby);
          if (apply_a !== w.app_a) report_mismatch("apply_a", apply_a, w.app_a);
          if (apply_b !== w.app_b) report_mismatch("apply_b", apply_b, w.app_b);
          if (impulse !== w.imp) report_mismatch("impulse", impulse, w.imp);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom();
      2: return $urandom_range(1, 32'h0010_0000);
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0000_4000, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'(longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(longint'($urandom_range(0, 32'h0400_0000)) - 64'sh0200_0000);
    endcase
  endfunction

  function automatic contact_t random_contact();
    contact_t c;
    c.vax = pick_velocity(); c.vay = pick_velocity();
    c.vbx = pick_velocity(); c.vby = pick_velocity();
    c.ma = pick_mass(); c.mb = pick_mass();
    // mostly in the stated range, sometimes any bit pattern
    if ($urandom_range(0, 9) == 0) begin
      c.nx = 16'($urandom()); c.ny = 16'($urandom());
    end else begin
      c.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
      c.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    if ($urandom_range(0, 9) == 0) begin
      c.ra = 17'($urandom()); c.rb = 17'($urandom());
    end else begin
      c.ra = 17'($urandom_range(0, 65536)); c.rb = 17'($urandom_range(0, 65536));
    end
    return c;
  endfunction

  task automatic add_contact(logic [31:0] vax, vay, ma, vbx, vby, mb,
                             logic [15:0] nx, ny, logic [16:0] ra, rb);
    contact_t c;
    c.vax = vax; c.vay = vay; c.ma = ma; c.vbx = vbx; c.vby = vby; c.mb = mb;
    c.nx = nx; c.ny = ny; c.ra = ra; c.rb = rb;
    pending_contacts.push_back(c);
  endtask

  task automatic drain();
    while (pending_contacts.size() > 0 || in_valid || expected_responses.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: head-on, static, separating, resting, extremes
    add_contact(32'h0001_0000, '0, 32'h0001_0000, 32'hFFFF_0000, '0, 32'h0001_0000,
                16'sd16384, '0, 17'd65536, 17'd65536);
    add_contact(32'h0001_0000, '0, 32'h0001_0000, '0, '0, '0, 16'sd16384, '0, '0, '0);
    add_contact('0, '0, '0, 32'hFFFF_0000, '0, 32'h0002_0000, 16'sd16384, '0,
                17'd32768, '0);
    add_contact(32'h0001_0000, '0, '0, 32'hFFFF_0000, '0, '0, 16'sd16384, '0,
                17'd65536, '0);
    add_contact(32'hFFFF_0000, '0, 32'h0001_0000, 32'h0001_0000, '0, 32'h0001_0000,
                16'sd16384, '0, '0, '0);
    add_contact(32'h0001_0000, '0, 32'h0001_0000, 32'h0001_0000, '0, 32'h0001_0000,
                16'sd16384, '0, '0, '0);
    add_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'hFFFF_FFFF, 16'sh4000, 16'sh4000, 17'h1FFFF, 17'h1FFFF);
    add_contact(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
                32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'shC000, 16'shC000, 17'd65536, '0);
    add_contact(32'h7FFF_FFFF, '0, 32'hFFFF_FFFF, 32'h8000_0000, '0, '0,
                16'sd16384, '0, 17'd65536, 17'd65536);
    add_contact(32'd1, '0, 32'h0001_0000, '0, '0, 32'h0001_0000, 16'sd16384, '0, '0, '0);
    add_contact('0, 32'h0001_0000, 32'h0001_0000, '0, '0, 32'h0001_0000,
                16'sd11585, 16'sd11585, 17'd65536, 17'd65536);
    add_contact(32'h0005_0000, 32'hFFFD_0000, 32'h0003_0000, 32'hFFFE_0000,
                32'h0002_0000, 32'h0000_8000, 16'sh7FFF, 16'sh8000, 17'h1FFFF, '0);
    add_contact(32'h0001_0000, '0, 32'h0001_0000, 32'hFFFF_0000, '0, 32'h0001_0000,
                16'shC000, '0, '0, '0);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_left = HOLD_CYCLES;
    repeat (100) pending_contacts.push_back(random_contact());
    drain();

    // back-to-back stretch with no idling
    random_gaps = 0;
    repeat (200) pending_contacts.push_back(random_contact());
    drain();
    random_gaps = 1;

    repeat (1400) pending_contacts.push_back(random_contact());
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/cir_pkg.sv
hw/rtl/cir_div.sv
hw/rtl/collision_impulse_response_top.sv
hw/rtl/cir_chk.sv
sim/collision_impulse_response_top_tb.sv
